// ===== sv/i2cra_pkg.sv =====
// Shared types and codes for the I2C register access sequencer.
// Used by i2cra_regs, i2cra_step and the top level; no dependencies.
`timescale 1ns / 1ps

package i2cra_pkg;

  localparam logic [6:0] SLAVE_ADDRESS_RESET = 7'd80;
  localparam logic [7:0] MAX_RETRIES_RESET   = 8'd20;
  localparam int unsigned PADDR_W = 3;

  // Register indexes on the configuration port (address bit 2).
  localparam logic REG_SLAVE_ADDRESS = 1'b0;
  localparam logic REG_MAX_RETRIES   = 1'b1;

  typedef enum logic [1:0] {
    FUNC_WRITE_REQ = 2'd0,
    FUNC_READ_REQ  = 2'd1,
    FUNC_STATUS    = 2'd2,
    FUNC_NOP       = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_START   = 3'd1,
    PH_SLAW    = 3'd2,
    PH_CMD     = 3'd3,
    PH_DATA    = 3'd4,
    PH_RESTART = 3'd5,
    PH_SLAR    = 3'd6,
    PH_RX      = 3'd7
  } phase_e;

  typedef enum logic [2:0] {
    ACT_NONE  = 3'd0,
    ACT_START = 3'd1,
    ACT_STOP  = 3'd2,
    ACT_TX    = 3'd3,
    ACT_RX    = 3'd4
  } action_e;

  typedef enum logic [3:0] {
    RC_OK          = 4'd0,
    RC_START_FAIL  = 4'd1,
    RC_SLAW_ERR    = 4'd2,
    RC_CMD_NACK    = 4'd3,
    RC_CMD_ERR     = 4'd4,
    RC_RESTART_ERR = 4'd5,
    RC_SLAR_NACK   = 4'd6,
    RC_SLAR_ERR    = 4'd7,
    RC_DATA_NACK   = 4'd8,
    RC_DATA_ERR    = 4'd9,
    RC_RETRIES_OUT = 4'd10
  } result_e;

  // Bus status codes, already divided by eight.
  localparam logic [4:0] ST_START     = 5'd1;
  localparam logic [4:0] ST_REP_START = 5'd2;
  localparam logic [4:0] ST_SLAW_ACK  = 5'd3;
  localparam logic [4:0] ST_SLAW_NACK = 5'd4;
  localparam logic [4:0] ST_TXD_ACK   = 5'd5;
  localparam logic [4:0] ST_TXD_NACK  = 5'd6;
  localparam logic [4:0] ST_ARB_LOST  = 5'd7;
  localparam logic [4:0] ST_SLAR_ACK  = 5'd8;
  localparam logic [4:0] ST_SLAR_NACK = 5'd9;
  localparam logic [4:0] ST_RXD_ACK   = 5'd10;
  localparam logic [4:0] ST_RXD_NACK  = 5'd11;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] cmd_byte;
    logic [7:0] data_byte;
    logic [4:0] bus_status;
    logic [7:0] rx_byte;
  } item_t;

  typedef struct packed {
    phase_e     phase;
    logic       read_mode;
    logic [7:0] command_reg;
    logic [7:0] write_value;
    logic [7:0] attempts_used;
  } ctx_t;

  typedef struct packed {
    action_e    bus_action;
    logic [7:0] tx_byte;
    logic       done_res;
    result_e    result_code;
    logic [7:0] read_data;
  } result_t;

  typedef struct packed {
    logic [6:0] slave_address;
    logic [7:0] max_retries;
  } cfg_t;

endpackage

// ===== sv/i2cra_regs.sv =====
// APB-style configuration registers: slave address and retry limit.
// Depends on i2cra_pkg.
`timescale 1ns / 1ps

module i2cra_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [i2cra_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  output i2cra_pkg::cfg_t               cfg_o
);

  logic [6:0] slave_address_q;
  logic [7:0] max_retries_q;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slave_address_q <= i2cra_pkg::SLAVE_ADDRESS_RESET;
      max_retries_q   <= i2cra_pkg::MAX_RETRIES_RESET;
    end else if (wr_en) begin
      unique case (paddr[2])
        i2cra_pkg::REG_SLAVE_ADDRESS: slave_address_q <= pwdata[6:0];
        i2cra_pkg::REG_MAX_RETRIES:   max_retries_q   <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      i2cra_pkg::REG_SLAVE_ADDRESS: prdata = {25'd0, slave_address_q};
      i2cra_pkg::REG_MAX_RETRIES:   prdata = {24'd0, max_retries_q};
      default:                      prdata = 32'd0;
    endcase
  end

  assign cfg_o.slave_address = slave_address_q;
  assign cfg_o.max_retries   = max_retries_q;

endmodule

// ===== sv/i2cra_step.sv =====
// Phase transition and bus action logic for one request or status event.
// Purely combinational; depends on i2cra_pkg.
`timescale 1ns / 1ps

module i2cra_step (
  input  i2cra_pkg::item_t   item_i,
  input  i2cra_pkg::ctx_t    ctx_i,
  input  i2cra_pkg::cfg_t    cfg_i,
  output i2cra_pkg::ctx_t    ctx_o,
  output i2cra_pkg::result_t res_o
);

  logic       is_req;
  logic       is_status;
  logic       start_ok;
  logic       arb_restart;
  logic [7:0] addr_w;
  logic [7:0] att_inc;
  logic       retries_out;

  assign is_req    = (item_i.func == i2cra_pkg::FUNC_WRITE_REQ ||
                      item_i.func == i2cra_pkg::FUNC_READ_REQ) &&
                     ctx_i.phase == i2cra_pkg::PH_IDLE;
  assign is_status = item_i.func == i2cra_pkg::FUNC_STATUS;
  assign start_ok  = item_i.bus_status == i2cra_pkg::ST_START ||
                     item_i.bus_status == i2cra_pkg::ST_REP_START;
  // Lost arbitration during start, address or command phases simply retries the start.
  assign arb_restart = item_i.bus_status == i2cra_pkg::ST_ARB_LOST &&
                       (ctx_i.phase == i2cra_pkg::PH_START ||
                        ctx_i.phase == i2cra_pkg::PH_SLAW ||
                        ctx_i.phase == i2cra_pkg::PH_CMD ||
                        ctx_i.phase == i2cra_pkg::PH_RESTART ||
                        ctx_i.phase == i2cra_pkg::PH_SLAR);
  assign addr_w      = {cfg_i.slave_address, 1'b0};
  assign att_inc     = (ctx_i.attempts_used != 8'hFF) ? ctx_i.attempts_used + 8'd1
                                                      : ctx_i.attempts_used;
  assign retries_out = att_inc >= cfg_i.max_retries;

  // Next phase and context.
  always_comb begin
    ctx_o = ctx_i;
    priority if (is_req) begin
      ctx_o.read_mode     = item_i.func == i2cra_pkg::FUNC_READ_REQ;
      ctx_o.command_reg   = {item_i.cmd_byte[7:1],
                             item_i.func == i2cra_pkg::FUNC_READ_REQ};
      ctx_o.write_value   = item_i.data_byte;
      ctx_o.attempts_used = 8'd0;
      ctx_o.phase         = i2cra_pkg::PH_START;
    end else if (is_status && arb_restart) begin
      ctx_o.phase = i2cra_pkg::PH_START;
    end else if (is_status) begin
      unique case (ctx_i.phase)
        i2cra_pkg::PH_START:
          ctx_o.phase = start_ok ? i2cra_pkg::PH_SLAW : i2cra_pkg::PH_IDLE;
        i2cra_pkg::PH_SLAW: begin
          priority if (item_i.bus_status == i2cra_pkg::ST_SLAW_ACK) begin
            ctx_o.phase = i2cra_pkg::PH_CMD;
          end else if (item_i.bus_status == i2cra_pkg::ST_SLAW_NACK) begin
            ctx_o.attempts_used = att_inc;
            ctx_o.phase = retries_out ? i2cra_pkg::PH_IDLE : i2cra_pkg::PH_START;
          end else begin
            ctx_o.phase = i2cra_pkg::PH_IDLE;
          end
        end
        i2cra_pkg::PH_CMD: begin
          if (item_i.bus_status == i2cra_pkg::ST_TXD_ACK) begin
            ctx_o.phase = ctx_i.read_mode ? i2cra_pkg::PH_RESTART : i2cra_pkg::PH_DATA;
          end else begin
            ctx_o.phase = i2cra_pkg::PH_IDLE;
          end
        end
        i2cra_pkg::PH_RESTART:
          ctx_o.phase = start_ok ? i2cra_pkg::PH_SLAR : i2cra_pkg::PH_IDLE;
        i2cra_pkg::PH_SLAR:
          ctx_o.phase = (item_i.bus_status == i2cra_pkg::ST_SLAR_ACK) ?
                        i2cra_pkg::PH_RX : i2cra_pkg::PH_IDLE;
        default:
          ctx_o.phase = i2cra_pkg::PH_IDLE;
      endcase
    end
  end

  // Bus action and result for this item.
  always_comb begin
    res_o.bus_action  = i2cra_pkg::ACT_NONE;
    res_o.tx_byte     = 8'd0;
    res_o.done_res    = 1'b0;
    res_o.result_code = i2cra_pkg::RC_OK;
    res_o.read_data   = 8'd0;
    priority if (is_req || (is_status && arb_restart)) begin
      res_o.bus_action = i2cra_pkg::ACT_START;
    end else if (is_status) begin
      unique case (ctx_i.phase)
        i2cra_pkg::PH_IDLE: ;
        i2cra_pkg::PH_START: begin
          if (start_ok) begin
            res_o.bus_action = i2cra_pkg::ACT_TX;
            res_o.tx_byte    = addr_w;
          end else begin
            // A failed start ends the transfer without a stop.
            res_o.done_res    = 1'b1;
            res_o.result_code = i2cra_pkg::RC_START_FAIL;
          end
        end
        i2cra_pkg::PH_SLAW: begin
          priority if (item_i.bus_status == i2cra_pkg::ST_SLAW_ACK) begin
            res_o.bus_action = i2cra_pkg::ACT_TX;
            res_o.tx_byte    = ctx_i.command_reg;
          end else if (item_i.bus_status == i2cra_pkg::ST_SLAW_NACK) begin
            if (retries_out) begin
              res_o.bus_action  = i2cra_pkg::ACT_STOP;
              res_o.done_res    = 1'b1;
              res_o.result_code = i2cra_pkg::RC_RETRIES_OUT;
            end else begin
              res_o.bus_action = i2cra_pkg::ACT_START;
            end
          end else begin
            res_o.bus_action  = i2cra_pkg::ACT_STOP;
            res_o.done_res    = 1'b1;
            res_o.result_code = i2cra_pkg::RC_SLAW_ERR;
          end
        end
        i2cra_pkg::PH_CMD: begin
          priority if (item_i.bus_status == i2cra_pkg::ST_TXD_ACK) begin
            if (ctx_i.read_mode) begin
              res_o.bus_action = i2cra_pkg::ACT_START;
            end else begin
              res_o.bus_action = i2cra_pkg::ACT_TX;
              res_o.tx_byte    = ctx_i.write_value;
            end
          end else if (item_i.bus_status == i2cra_pkg::ST_TXD_NACK) begin
            res_o.bus_action  = i2cra_pkg::ACT_STOP;
            res_o.done_res    = 1'b1;
            res_o.result_code = i2cra_pkg::RC_CMD_NACK;
          end else begin
            res_o.bus_action  = i2cra_pkg::ACT_STOP;
            res_o.done_res    = 1'b1;
            res_o.result_code = i2cra_pkg::RC_CMD_ERR;
          end
        end
        i2cra_pkg::PH_DATA: begin
          res_o.bus_action = i2cra_pkg::ACT_STOP;
          res_o.done_res   = 1'b1;
          priority if (item_i.bus_status == i2cra_pkg::ST_TXD_ACK) begin
            res_o.result_code = i2cra_pkg::RC_OK;
          end else if (item_i.bus_status == i2cra_pkg::ST_TXD_NACK) begin
            res_o.result_code = i2cra_pkg::RC_DATA_NACK;
          end else begin
            res_o.result_code = i2cra_pkg::RC_DATA_ERR;
          end
        end
        i2cra_pkg::PH_RESTART: begin
          if (start_ok) begin
            res_o.bus_action = i2cra_pkg::ACT_TX;
            res_o.tx_byte    = {cfg_i.slave_address, 1'b1};
          end else begin
            res_o.bus_action  = i2cra_pkg::ACT_STOP;
            res_o.done_res    = 1'b1;
            res_o.result_code = i2cra_pkg::RC_RESTART_ERR;
          end
        end
        i2cra_pkg::PH_SLAR: begin
          priority if (item_i.bus_status == i2cra_pkg::ST_SLAR_ACK) begin
            res_o.bus_action = i2cra_pkg::ACT_RX;
          end else if (item_i.bus_status == i2cra_pkg::ST_SLAR_NACK) begin
            res_o.bus_action  = i2cra_pkg::ACT_STOP;
            res_o.done_res    = 1'b1;
            res_o.result_code = i2cra_pkg::RC_SLAR_NACK;
          end else begin
            res_o.bus_action  = i2cra_pkg::ACT_STOP;
            res_o.done_res    = 1'b1;
            res_o.result_code = i2cra_pkg::RC_SLAR_ERR;
          end
        end
        i2cra_pkg::PH_RX: begin
          res_o.bus_action = i2cra_pkg::ACT_STOP;
          res_o.done_res   = 1'b1;
          priority if (item_i.bus_status == i2cra_pkg::ST_RXD_ACK) begin
            res_o.result_code = i2cra_pkg::RC_OK;
            res_o.read_data   = item_i.rx_byte;
          end else if (item_i.bus_status == i2cra_pkg::ST_RXD_NACK) begin
            res_o.result_code = i2cra_pkg::RC_DATA_NACK;
          end else begin
            res_o.result_code = i2cra_pkg::RC_DATA_ERR;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== sv/i2c_master_register_access_core.sv =====
// I2C register access sequencer: each input transfer passes through the input
// register, then through the phase logic into the result register.
// Throughput: one item per cycle unless the output stalls; the phase context is
// updated as each item moves into the result register, so the next item sees it
// immediately. Reset (rst_ni low, asynchronous): phase idle, context cleared,
// both stages empty, slave address 80, retry limit 20.
`timescale 1ns / 1ps

module i2c_master_register_access_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [i2cra_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  // Input channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    func_i,
  input  logic [7:0]                    cmd_byte_i,
  input  logic [7:0]                    data_byte_i,
  input  logic [4:0]                    bus_status_i,
  input  logic [7:0]                    rx_byte_i,
  // Output channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [2:0]                    bus_action_o,
  output logic [7:0]                    tx_byte_o,
  output logic                          done_res_o,
  output logic [3:0]                    result_code_o,
  output logic [7:0]                    read_data_o
);

  i2cra_pkg::cfg_t    cfg;
  i2cra_pkg::item_t   item_q;
  i2cra_pkg::ctx_t    ctx_q;
  i2cra_pkg::ctx_t    ctx_d;
  i2cra_pkg::result_t res_d;
  i2cra_pkg::result_t res_q;
  logic               in_full_q;
  logic               out_full_q;
  logic               advance;
  logic               in_take;

  i2cra_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  i2cra_step u_step (
    .item_i (item_q),
    .ctx_i  (ctx_q),
    .cfg_i  (cfg),
    .ctx_o  (ctx_d),
    .res_o  (res_d)
  );

  // The held item moves on whenever the result register is free or being drained.
  assign advance    = in_full_q && (!out_full_q || !out_stall_i);
  assign in_stall_o = in_full_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_full_q  <= 1'b0;
      out_full_q <= 1'b0;
      ctx_q      <= '{phase: i2cra_pkg::PH_IDLE, read_mode: 1'b0,
                      command_reg: 8'd0, write_value: 8'd0, attempts_used: 8'd0};
    end else begin
      if (in_take) begin
        in_full_q <= 1'b1;
      end else if (advance) begin
        in_full_q <= 1'b0;
      end
      if (advance) begin
        out_full_q <= 1'b1;
        ctx_q      <= ctx_d;
      end else if (!out_stall_i) begin
        out_full_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q <= '{func: func_i, cmd_byte: cmd_byte_i, data_byte: data_byte_i,
                  bus_status: bus_status_i, rx_byte: rx_byte_i};
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o   = out_full_q;
  assign bus_action_o  = res_q.bus_action;
  assign tx_byte_o     = res_q.tx_byte;
  assign done_res_o    = res_q.done_res;
  assign result_code_o = res_q.result_code;
  assign read_data_o   = res_q.read_data;

endmodule

// ===== tb/i2cra_sequence_checker.sv =====
// Transfer checker for the I2C register access sequencer: predicts each bus step
// from the accepted input transfers, compares the result transfers field by field and checks register reads.
// Depends on i2cra_pkg for the item, result, phase, action and status codes.
`timescale 1ns / 1ps

module i2cra_sequence_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [i2cra_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                   pwdata,
  input  logic [31:0]                   prdata,
  input  logic                          pready,
  input  logic                          in_valid_i,
  input  logic                          in_stall_o,
  input  logic [1:0]                    func_i,
  input  logic [7:0]                    cmd_byte_i,
  input  logic [7:0]                    data_byte_i,
  input  logic [4:0]                    bus_status_i,
  input  logic [7:0]                    rx_byte_i,
  input  logic                          out_valid_o,
  input  logic                          out_stall_i,
  input  logic [2:0]                    bus_action_o,
  input  logic [7:0]                    tx_byte_o,
  input  logic                          done_res_o,
  input  logic [3:0]                    result_code_o,
  input  logic [7:0]                    read_data_o,
  output int                            fail_count_o,
  output int                            pending_o,
  output int                            results_o,
  output int                            ended_o,
  output int                            failed_o
);
  import i2cra_pkg::*;

  // Local copy of the sequencer context and its configuration.
  phase_e     ph;
  logic       rd_mode;
  logic [7:0] cmd_q;
  logic [7:0] wr_q;
  logic [7:0] tries;
  logic [6:0] cfg_addr;
  logic [7:0] cfg_retries;

  result_t pending_steps[$];
  int fail_count = 0;
  int results_seen = 0;
  int txn_ended = 0;
  int txn_failed = 0;

  assign fail_count_o = fail_count;
  assign results_o    = results_seen;
  assign ended_o      = txn_ended;
  assign failed_o     = txn_failed;

  task automatic flag_mismatch(input string what, input int unsigned got,
                               input int unsigned want);
    if (fail_count < 60) begin
      $display("%0t ns: mismatch at result %0d, %s: got 0x%0h, expected 0x%0h",
               $time, results_seen, what, got, want);
    end
    fail_count++;
  endtask

  // Advances the local context by one input item and returns the bus step it causes.
  function automatic result_t next_bus_step(input item_t it);
    result_t    r;
    action_e    act;
    result_e    rc;
    logic [7:0] txb;
    logic [7:0] addr_w;
    logic       fin;
    logic [4:0] st;
    act    = ACT_NONE;
    rc     = RC_OK;
    txb    = 8'h00;
    fin    = 1'b0;
    r      = '0;
    st     = it.bus_status;
    addr_w = {cfg_addr, 1'b0};
    if ((it.func == FUNC_WRITE_REQ || it.func == FUNC_READ_REQ) && ph == PH_IDLE) begin
      rd_mode = (it.func == FUNC_READ_REQ);
      cmd_q   = rd_mode ? (it.cmd_byte | 8'h01) : (it.cmd_byte & 8'hFE);
      wr_q    = it.data_byte;
      tries   = 8'h00;
      ph      = PH_START;
      act     = ACT_START;
    end else if (it.func == FUNC_STATUS) begin
      // Lost arbitration before any data byte goes out simply starts over.
      if (st == ST_ARB_LOST && (ph == PH_START || ph == PH_SLAW || ph == PH_CMD ||
                                ph == PH_RESTART || ph == PH_SLAR)) begin
        ph  = PH_START;
        act = ACT_START;
      end else begin
        case (ph)
          PH_START: begin
            if (st == ST_START || st == ST_REP_START) begin
              ph  = PH_SLAW;
              act = ACT_TX;
              txb = addr_w;
            end else begin
              fin = 1'b1;
              rc  = RC_START_FAIL;
            end
          end
          PH_SLAW: begin
            if (st == ST_SLAW_ACK) begin
              ph  = PH_CMD;
              act = ACT_TX;
              txb = cmd_q;
            end else if (st == ST_SLAW_NACK) begin
              if (tries != 8'hFF) tries = tries + 8'd1;
              if (tries >= cfg_retries) begin
                fin = 1'b1;
                act = ACT_STOP;
                rc  = RC_RETRIES_OUT;
              end else begin
                ph  = PH_START;
                act = ACT_START;
              end
            end else begin
              fin = 1'b1;
              act = ACT_STOP;
              rc  = RC_SLAW_ERR;
            end
          end
          PH_CMD: begin
            if (st == ST_TXD_ACK) begin
              if (rd_mode) begin
                ph  = PH_RESTART;
                act = ACT_START;
              end else begin
                ph  = PH_DATA;
                act = ACT_TX;
                txb = wr_q;
              end
            end else begin
              fin = 1'b1;
              act = ACT_STOP;
              rc  = (st == ST_TXD_NACK) ? RC_CMD_NACK : RC_CMD_ERR;
            end
          end
          PH_DATA: begin
            fin = 1'b1;
            act = ACT_STOP;
            if (st == ST_TXD_ACK) rc = RC_OK;
            else if (st == ST_TXD_NACK) rc = RC_DATA_NACK;
            else rc = RC_DATA_ERR;
          end
          PH_RESTART: begin
            if (st == ST_START || st == ST_REP_START) begin
              ph  = PH_SLAR;
              act = ACT_TX;
              txb = addr_w | 8'h01;
            end else begin
              fin = 1'b1;
              act = ACT_STOP;
              rc  = RC_RESTART_ERR;
            end
          end
          PH_SLAR: begin
            if (st == ST_SLAR_ACK) begin
              ph  = PH_RX;
              act = ACT_RX;
            end else begin
              fin = 1'b1;
              act = ACT_STOP;
              rc  = (st == ST_SLAR_NACK) ? RC_SLAR_NACK : RC_SLAR_ERR;
            end
          end
          PH_RX: begin
            fin = 1'b1;
            act = ACT_STOP;
            if (st == ST_RXD_ACK) begin
              rc          = RC_OK;
              r.read_data = it.rx_byte;
            end else if (st == ST_RXD_NACK) begin
              rc = RC_DATA_NACK;
            end else begin
              rc = RC_DATA_ERR;
            end
          end
          default: ph = PH_IDLE;
        endcase
      end
    end
    if (fin) ph = PH_IDLE;
    r.bus_action  = act;
    r.tx_byte     = txb;
    r.done_res    = fin;
    r.result_code = rc;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    result_t     want;
    item_t       it;
    logic [31:0] reg_value;
    if (!rst_ni) begin
      ph          = PH_IDLE;
      rd_mode     = 1'b0;
      cmd_q       = 8'h00;
      wr_q        = 8'h00;
      tries       = 8'h00;
      cfg_addr    = SLAVE_ADDRESS_RESET;
      cfg_retries = MAX_RETRIES_RESET;
      pending_steps.delete();
      pending_o <= 0;
    end else begin
      if (psel && penable && pready) begin
        if (pwrite) begin
          if (paddr[2] == REG_SLAVE_ADDRESS) cfg_addr = pwdata[6:0];
          else cfg_retries = pwdata[7:0];
        end else begin
          reg_value = (paddr[2] == REG_SLAVE_ADDRESS) ? {25'd0, cfg_addr} : {24'd0, cfg_retries};
          if (prdata !== reg_value) flag_mismatch("register readback", prdata, reg_value);
        end
      end
      if (out_valid_o && !out_stall_i) begin
        results_seen++;
        if (pending_steps.size() == 0) begin
          flag_mismatch("result with no input transfer pending", bus_action_o, 0);
        end else begin
          want = pending_steps.pop_front();
          if (bus_action_o !== want.bus_action)
            flag_mismatch("bus_action", bus_action_o, want.bus_action);
          if (tx_byte_o !== want.tx_byte)
            flag_mismatch("tx_byte", tx_byte_o, want.tx_byte);
          if (done_res_o !== want.done_res)
            flag_mismatch("done_res", done_res_o, want.done_res);
          if (result_code_o !== want.result_code)
            flag_mismatch("result_code", result_code_o, want.result_code);
          if (read_data_o !== want.read_data)
            flag_mismatch("read_data", read_data_o, want.read_data);
          if (want.done_res) begin
            txn_ended++;
            if (want.result_code != RC_OK) txn_failed++;
          end
        end
      end
      if (in_valid_i && !in_stall_o) begin
        it = {func_i, cmd_byte_i, data_byte_i, bus_status_i, rx_byte_i};
        pending_steps.push_back(next_bus_step(it));
      end
      pending_o <= pending_steps.size();
    end
  end

endmodule

// ===== tb/tb_i2c_master_register_access_core.sv =====
// Top of the I2C register access sequencer testbench: clock, reset, register
// programming, transaction stimulus, receiver stalls, watchdog and verdict.
// Depends on i2cra_pkg, the core and i2cra_sequence_checker.
`timescale 1ns / 1ps

module tb_i2c_master_register_access_core;
  import i2cra_pkg::*;

  localparam int ITEMS_PER_SETTING = 180;
  localparam int HOLDOFF_CYCLES    = 80;
  localparam int WATCHDOG_LIMIT    = 1000;

  logic               clk_i;
  logic               rst_ni      = 1'b0;
  logic               psel        = 1'b0;
  logic               penable     = 1'b0;
  logic               pwrite      = 1'b0;
  logic [PADDR_W-1:0] paddr       = '0;
  logic [31:0]        pwdata      = '0;
  logic [31:0]        prdata;
  logic               pready;
  logic               in_valid_i  = 1'b0;
  logic               in_stall_o;
  logic [1:0]         func_i      = FUNC_NOP;
  logic [7:0]         cmd_byte_i  = '0;
  logic [7:0]         data_byte_i = '0;
  logic [4:0]         bus_status_i = '0;
  logic [7:0]         rx_byte_i   = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [2:0]         bus_action_o;
  logic [7:0]         tx_byte_o;
  logic               done_res_o;
  logic [3:0]         result_code_o;
  logic [7:0]         read_data_o;

  int fail_count;
  int pending;
  int results_seen;
  int txn_ended;
  int txn_failed;

  int items_sent = 0;
  int settings_used = 0;
  logic no_idle = 1'b0;
  int holdoff_requests = 0;

  i2c_master_register_access_core DUT (.*);

  i2cra_sequence_checker u_checker (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid_i, .in_stall_o, .func_i, .cmd_byte_i, .data_byte_i, .bus_status_i,
    .rx_byte_i, .out_valid_o, .out_stall_i, .bus_action_o, .tx_byte_o, .done_res_o,
    .result_code_o, .read_data_o,
    .fail_count_o(fail_count), .pending_o(pending), .results_o(results_seen),
    .ended_o(txn_ended), .failed_o(txn_failed)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Ends the run when neither channel has moved a transfer for too long.
  always @(posedge clk_i) begin
    int quiet_cycles;
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog: no transfer for %0d cycles, %0d results outstanding",
                 quiet_cycles, pending);
        $display("tb_i2c_master_register_access_core failed");
        $finish;
      end
    end
  end

  // Receiver: random stall runs, plus a long hold-off whenever one is requested.
  initial begin
    int holdoffs_served;
    int run;
    int r;
    holdoffs_served = 0;
    run = 0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (holdoff_requests != holdoffs_served) begin
        holdoffs_served++;
        out_stall_i <= 1'b1;
        repeat (HOLDOFF_CYCLES) @(posedge clk_i);
        run = 0;
      end else if (no_idle) begin
        out_stall_i <= 1'b0;
      end else if (run > 0) begin
        run--;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 30) begin
          out_stall_i <= 1'b1;
          run = (r < 27) ? $urandom_range(0, 2) : $urandom_range(10, 40);
        end else begin
          out_stall_i <= 1'b0;
          run = $urandom_range(0, 15);
        end
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Offers one item and returns once it has been transferred, then idles a while.
  task automatic offer(input logic [1:0] fn, input logic [7:0] cmd, input logic [7:0] dat,
                       input logic [4:0] st, input logic [7:0] rx);
    int gap;
    in_valid_i   <= 1'b1;
    func_i       <= fn;
    cmd_byte_i   <= cmd;
    data_byte_i  <= dat;
    bus_status_i <= st;
    rx_byte_i    <= rx;
    do @(posedge clk_i); while (in_stall_o);
    items_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic offer_status(input logic [4:0] st);
    offer(FUNC_STATUS, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), st,
          8'($urandom_range(0, 255)));
  endtask

  task automatic offer_noise();
    offer(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
          5'($urandom_range(0, 31)), 8'($urandom_range(0, 255)));
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  task automatic apb_access(input logic wr, input logic idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Upper data bits are random so that the register width is exercised too.
  task automatic reconfigure(input logic [6:0] addr, input logic [7:0] retries);
    settle();
    repeat (4) @(posedge clk_i);
    apb_access(1'b1, REG_SLAVE_ADDRESS, ($urandom & 32'hFFFF_FF80) | addr);
    apb_access(1'b1, REG_MAX_RETRIES, ($urandom & 32'hFFFF_FF00) | retries);
    apb_access(1'b0, REG_SLAVE_ADDRESS, 32'd0);
    apb_access(1'b0, REG_MAX_RETRIES, 32'd0);
    settings_used++;
  endtask

  // One request followed by its status events, with lost arbitration, SLA+W
  // NACKs, broken sequences and stray items mixed in.
  task automatic run_transaction();
    logic [4:0] path[$];
    logic [4:0] st;
    logic       rd;
    int         step;
    int         restarts;
    int         nacks_left;
    int         r;
    rd = 1'($urandom_range(0, 1));
    nacks_left = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 30) : 0;
    path.push_back(ST_START);
    path.push_back(ST_SLAW_ACK);
    path.push_back(ST_TXD_ACK);
    if (rd) begin
      path.push_back(ST_REP_START);
      path.push_back(ST_SLAR_ACK);
      path.push_back(ST_RXD_ACK);
    end else begin
      path.push_back(ST_TXD_ACK);
    end
    offer(rd ? FUNC_READ_REQ : FUNC_WRITE_REQ, 8'($urandom_range(0, 255)),
          8'($urandom_range(0, 255)), 5'($urandom_range(0, 31)),
          8'($urandom_range(0, 255)));
    step = 0;
    restarts = 0;
    while (step < path.size()) begin
      r = $urandom_range(0, 99);
      if (r < 3) begin
        offer_noise();
      end else if (r < 7) begin
        offer_status(5'($urandom_range(0, 31)));
        step = path.size();
      end else if (r < 11 && restarts < 3) begin
        // On the last byte a lost arbitration is a plain error.
        offer_status(ST_ARB_LOST);
        restarts++;
        step = (step == path.size() - 1) ? path.size() : 0;
      end else if (step == 1 && (nacks_left > 0 || r < 20)) begin
        offer_status(ST_SLAW_NACK);
        if (nacks_left > 0) nacks_left--;
        step = 0;
      end else begin
        st = path[step];
        if (st == ST_START || st == ST_REP_START)
          st = $urandom_range(0, 1) ? ST_START : ST_REP_START;
        offer_status(st);
        step++;
      end
    end
  endtask

  initial begin
    logic [6:0] addr_tab[6];
    logic [7:0] retry_tab[6];
    int target;
    logic paused;
    addr_tab[0] = 7'd0;                         retry_tab[0] = 8'd1;
    addr_tab[1] = 7'd127;                       retry_tab[1] = 8'd255;
    addr_tab[2] = 7'($urandom_range(0, 127));   retry_tab[2] = 8'd3;
    addr_tab[3] = 7'($urandom_range(0, 127));   retry_tab[3] = 8'd0;
    addr_tab[4] = SLAVE_ADDRESS_RESET;          retry_tab[4] = MAX_RETRIES_RESET;
    addr_tab[5] = 7'($urandom_range(0, 127));   retry_tab[5] = 8'($urandom_range(1, 255));
    paused = 1'b0;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // Reset values first, then a one-attempt limit for the directed part.
    apb_access(1'b0, REG_SLAVE_ADDRESS, 32'd0);
    apb_access(1'b0, REG_MAX_RETRIES, 32'd0);
    reconfigure(SLAVE_ADDRESS_RESET, 8'd1);

    // Complete write with extreme bytes.
    offer(FUNC_WRITE_REQ, 8'hFF, 8'h00, 5'd0, 8'h00);
    offer(FUNC_STATUS, 8'h00, 8'hFF, ST_START, 8'h00);
    offer(FUNC_STATUS, 8'h00, 8'h00, ST_SLAW_ACK, 8'h00);
    offer(FUNC_STATUS, 8'hFF, 8'h00, ST_TXD_ACK, 8'hFF);
    offer(FUNC_STATUS, 8'h00, 8'h00, ST_TXD_ACK, 8'h00);
    // Read with lost arbitration at the repeated start.
    offer(FUNC_READ_REQ, 8'h00, 8'hFF, 5'd31, 8'hFF);
    offer(FUNC_STATUS, 8'h00, 8'h00, ST_REP_START, 8'h00);
    offer(FUNC_STATUS, 8'h00, 8'h00, ST_SLAW_ACK, 8'h00);
    offer(FUNC_STATUS, 8'h00, 8'h00, ST_TXD_ACK, 8'h00);
    offer(FUNC_STATUS, 8'h00, 8'h00, ST_ARB_LOST, 8'h00);
    offer(FUNC_STATUS, 8'h00, 8'h00, ST_START, 8'h00);
    offer(FUNC_STATUS, 8'h00, 8'h00, ST_SLAW_ACK, 8'h00);
    offer(FUNC_STATUS, 8'h00, 8'h00, ST_TXD_ACK, 8'h00);
    offer(FUNC_STATUS, 8'h00, 8'h00, ST_START, 8'h00);
    offer(FUNC_STATUS, 8'h00, 8'h00, ST_SLAR_ACK, 8'h00);
    offer(FUNC_STATUS, 8'h00, 8'h00, ST_RXD_ACK, 8'hFF);
    // Stray status while idle, a no-operation, and a request while busy.
    offer(FUNC_STATUS, 8'hFF, 8'hFF, 5'd31, 8'hFF);
    offer(FUNC_NOP, 8'hFF, 8'hFF, 5'd31, 8'hFF);
    offer(FUNC_WRITE_REQ, 8'h5A, 8'hA5, 5'd0, 8'h00);
    offer(FUNC_READ_REQ, 8'hC3, 8'h3C, 5'd0, 8'h00);
    // With a single attempt allowed the first SLA+W NACK gives up.
    offer(FUNC_STATUS, 8'h00, 8'h00, ST_START, 8'h00);
    offer(FUNC_STATUS, 8'h00, 8'h00, ST_SLAW_NACK, 8'h00);
    // Unknown status where a start is awaited.
    offer(FUNC_WRITE_REQ, 8'h01, 8'h80, 5'd0, 8'h00);
    offer(FUNC_STATUS, 8'h00, 8'h00, 5'd0, 8'h00);

    for (int s = 0; s < 6; s++) begin
      reconfigure(addr_tab[s], retry_tab[s]);
      no_idle <= (s == 2);
      if (s == 3) holdoff_requests <= holdoff_requests + 1;
      target = items_sent + ITEMS_PER_SETTING;
      while (items_sent < target) begin
        if (s == 4 && !paused && items_sent >= target - ITEMS_PER_SETTING / 2) begin
          settle();
          paused = 1'b1;
        end
        if ($urandom_range(0, 9) == 0) offer_noise();
        else run_transaction();
      end
    end
    no_idle <= 1'b0;

    settle();
    repeat (10) @(posedge clk_i);
    $display("Run covered %0d input transfers and %0d results under %0d register settings.",
             items_sent, results_seen, settings_used);
    $display("%0d transactions ended, %0d of them with an error code.",
             txn_ended, txn_failed);
    if (fail_count == 0) begin
      $display("tb_i2c_master_register_access_core passed");
    end else begin
      $display("tb_i2c_master_register_access_core failed");
    end
    $finish;
  end

endmodule
